// ===== sv/far_pkg.sv =====
// Shared types and constants for the fraction arithmetic block.
// Used by far_reduce and fraction_arith_reduce; no dependencies.
package far_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// status of the reduce unit as seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== sv/far_reduce.sv =====
// Reduce unit: binary gcd of two nonzero magnitudes, then two restoring
// divisions by that gcd, all on one shared subtractor. Depends on far_pkg.
module far_reduce #(
	parameter int MW = 2 * far_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MW-1:0]       n_mag,
	input  logic [MW-1:0]       d_mag,
	output far_pkg::unit_stat_t stat,
	output logic [MW-1:0]       q_n,
	output logic [MW-1:0]       q_d
);
	import far_pkg::*;

	localparam int KW = $clog2(MW);

	typedef enum logic [1:0] {R_IDLE, R_GCD, R_DIV_N, R_DIV_D} rstate_t;

	rstate_t         state_q;
	logic [MW-1:0]   a_q, b_q, g_q, rem_q, dvd_q, qn_q;
	logic [KW-1:0]   k_q, cnt_q;
	logic            done_q;

	logic            a_gt_b;
	logic [MW:0]     sub_x, sub_y;
	logic [MW+1:0]   sub_r;
	logic            borrow;

	assign a_gt_b = a_q > b_q;

	// one subtractor: larger minus smaller during gcd, trial subtract during divide
	always_comb begin
		if (state_q == R_GCD) begin
			sub_x = a_gt_b ? {1'b0, a_q} : {1'b0, b_q};
			sub_y = a_gt_b ? {1'b0, b_q} : {1'b0, a_q};
		end else begin
			sub_x = {rem_q, dvd_q[MW-1]};
			sub_y = {1'b0, g_q};
		end
		sub_r  = {1'b0, sub_x} - {1'b0, sub_y};
		borrow = sub_r[MW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			g_q     <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			qn_q    <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						a_q     <= n_mag;
						b_q     <= d_mag;
						k_q     <= '0;
						state_q <= R_GCD;
					end
				end
				R_GCD: begin
					if (a_q == b_q) begin
						g_q     <= a_q << k_q;
						rem_q   <= '0;
						dvd_q   <= n_mag;
						cnt_q   <= KW'(MW - 1);
						state_q <= R_DIV_N;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_gt_b) begin
						a_q <= sub_r[MW-1:0];
					end else begin
						b_q <= sub_r[MW-1:0];
					end
				end
				R_DIV_N, R_DIV_D: begin
					rem_q <= borrow ? sub_x[MW-1:0] : sub_r[MW-1:0];
					dvd_q <= {dvd_q[MW-2:0], ~borrow};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						if (state_q == R_DIV_N) begin
							qn_q    <= {dvd_q[MW-2:0], ~borrow};
							dvd_q   <= d_mag;
							rem_q   <= '0;
							cnt_q   <= KW'(MW - 1);
							state_q <= R_DIV_D;
						end else begin
							done_q  <= 1'b1;
							state_q <= R_IDLE;
						end
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != R_IDLE);
	assign stat.done = done_q;
	assign q_n       = qn_q;
	assign q_d       = dvd_q;

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == R_GCD |-> (a_q != '0 && b_q != '0))
		else $error("gcd operand reached zero");

	a_rem_below_g: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == R_DIV_N || state_q == R_DIV_D) |-> rem_q < g_q)
		else $error("divider remainder not below divisor");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == R_DIV_D)
		else $error("done without finishing second division");

endmodule

// ===== sv/fraction_arith_reduce.sv =====
// A zero numerator or zero denominator gives the result word without the reduce unit;
// otherwise the word passes the multiplier, the sum and the reduce unit's binary gcd
// and two divisions, MW = 2*OPERAND_WIDTH.
// Throughput: one word at a time; req_stall stays high until the result word is taken.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending.
module fraction_arith_reduce #(
	parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [1:0]                           opcode,
	input  logic signed [OPERAND_WIDTH-1:0]      num_a,
	input  logic signed [OPERAND_WIDTH-1:0]      den_a,
	input  logic signed [OPERAND_WIDTH-1:0]      num_b,
	input  logic signed [OPERAND_WIDTH-1:0]      den_b,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [far_pkg::NUM_OUT_W-1:0] res_num,
	output logic signed [far_pkg::DEN_OUT_W-1:0] res_den,
	output logic                                 status
);
	import far_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * OPERAND_WIDTH;
	localparam int PW = (MW > NUM_OUT_W) ? MW : NUM_OUT_W;

	typedef enum logic [2:0] {T_IDLE, T_MUL, T_SUM, T_RED, T_OUT} tstate_t;

	tstate_t               state_q;
	op_t                   op_q;
	logic [W-1:0]          na_q, da_q, nb_q, db_q;
	logic [1:0]            idx_q;
	logic [MW-1:0]         prod_s1;
	logic                  neg_s1;
	logic [MW:0]           acc_q;
	logic [MW-1:0]         dmag_q, nmag_q;
	logic                  dneg_q, nneg_q;
	logic                  start_q;
	logic [NUM_OUT_W-1:0]  res_num_q;
	logic [DEN_OUT_W-1:0]  res_den_q;
	logic                  status_q;

	logic [W-1:0]          mul_a, mul_b, a_mag, b_mag;
	logic                  mul_neg;
	logic [MW-1:0]         prod;
	logic [MW:0]           sv, n_abs;
	logic                  is_addsub;
	logic [PW-1:0]         num_ext, den_ext, num_pk, den_pk;

	unit_stat_t            red_stat;
	logic [MW-1:0]         red_qn, red_qd;

	assign is_addsub = (op_q == OP_ADD) || (op_q == OP_SUB);

	// factor selection for the shared multiplier
	always_comb begin
		mul_a   = na_q;
		mul_b   = (op_q == OP_MUL) ? nb_q : db_q;
		mul_neg = 1'b0;
		case (idx_q)
			2'd1: begin
				mul_a   = nb_q;
				mul_b   = da_q;
				mul_neg = (op_q == OP_SUB);
			end
			2'd2: begin
				mul_a = da_q;
				mul_b = (op_q == OP_DIV) ? nb_q : db_q;
			end
			default: ;
		endcase
		a_mag = mul_a[W-1] ? (~mul_a + 1'b1) : mul_a;
		b_mag = mul_b[W-1] ? (~mul_b + 1'b1) : mul_b;
		prod  = MW'(a_mag) * MW'(b_mag);
	end

	assign sv    = neg_s1 ? -{1'b0, prod_s1} : {1'b0, prod_s1};
	assign n_abs = acc_q[MW] ? -acc_q : acc_q;

	assign num_ext = PW'(red_qn);
	assign den_ext = PW'(red_qd);
	assign num_pk  = nneg_q ? -num_ext : num_ext;
	assign den_pk  = dneg_q ? -den_ext : den_ext;

	far_reduce #(.MW(MW)) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.n_mag  (nmag_q),
		.d_mag  (dmag_q),
		.stat   (red_stat),
		.q_n    (red_qn),
		.q_d    (red_qd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			op_q      <= OP_ADD;
			na_q      <= '0;
			da_q      <= '0;
			nb_q      <= '0;
			db_q      <= '0;
			idx_q     <= '0;
			prod_s1   <= '0;
			neg_s1    <= 1'b0;
			acc_q     <= '0;
			dmag_q    <= '0;
			dneg_q    <= 1'b0;
			nmag_q    <= '0;
			nneg_q    <= 1'b0;
			start_q   <= 1'b0;
			res_num_q <= '0;
			res_den_q <= '0;
			status_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (req_valid) begin
						op_q    <= op_t'(opcode);
						na_q    <= num_a;
						da_q    <= den_a;
						nb_q    <= num_b;
						db_q    <= den_b;
						idx_q   <= '0;
						state_q <= T_MUL;
					end
				end
				T_MUL: begin
					// issue product idx, fold in product idx-1
					prod_s1 <= prod;
					neg_s1  <= a_mag != '0 && b_mag != '0 &&
						(mul_a[W-1] ^ mul_b[W-1] ^ mul_neg);
					idx_q   <= idx_q + 2'd1;
					case (idx_q)
						2'd1: acc_q <= sv;
						2'd2: acc_q <= is_addsub ? acc_q + sv : acc_q;
						2'd3: begin
							dmag_q  <= prod_s1;
							dneg_q  <= neg_s1;
							state_q <= T_SUM;
						end
						default: ;
					endcase
				end
				T_SUM: begin
					nneg_q <= acc_q[MW];
					nmag_q <= n_abs[MW-1:0];
					if (dmag_q == '0) begin
						res_num_q <= '0;
						res_den_q <= '0;
						status_q  <= 1'b1;
						state_q   <= T_OUT;
					end else if (acc_q == '0) begin
						res_num_q <= '0;
						res_den_q <= DEN_OUT_W'(1);
						status_q  <= 1'b0;
						state_q   <= T_OUT;
					end else begin
						start_q <= 1'b1;
						state_q <= T_RED;
					end
				end
				T_RED: begin
					if (red_stat.done) begin
						res_num_q <= num_pk[NUM_OUT_W-1:0];
						res_den_q <= den_pk[DEN_OUT_W-1:0];
						status_q  <= 1'b0;
						state_q   <= T_OUT;
					end
				end
				T_OUT: begin
					if (!rsp_stall)
						state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != T_IDLE);
	assign rsp_valid = (state_q == T_OUT);
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign status    = status_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status) |-> (res_num == '0 && res_den == '0))
		else $error("error word carries nonzero result");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		red_stat.done |=> rsp_valid)
		else $error("reduce finished but no result word");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !red_stat.busy)
		else $error("reduce unit started while busy");

	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> !rsp_valid)
		else $error("new word taken with result pending");

endmodule

// ===== tb/fraction_check.sv =====
// Checker for fraction_arith_reduce: watches both channels, predicts each result
// from the accepted operand word and compares it field by field.
// Depends on far_pkg for the opcode enum and the result field widths.
module fraction_check #(
	parameter int W = far_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  logic                                 req_stall,
	input  logic [1:0]                           opcode,
	input  logic signed [W-1:0]                  num_a,
	input  logic signed [W-1:0]                  den_a,
	input  logic signed [W-1:0]                  num_b,
	input  logic signed [W-1:0]                  den_b,
	input  logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	input  logic signed [far_pkg::NUM_OUT_W-1:0] res_num,
	input  logic signed [far_pkg::DEN_OUT_W-1:0] res_den,
	input  logic                                 status,
	output int                                   mismatches,
	output int                                   in_flight
);
	import far_pkg::*;

	typedef struct {
		logic signed [NUM_OUT_W-1:0] num;
		logic signed [DEN_OUT_W-1:0] den;
		logic                        err;
	} fraction_t;

	fraction_t reduced_q[$];
	fraction_t want;
	int        bad;

	function automatic fraction_t reduce_fraction(op_t op, logic signed [W-1:0] na,
		logic signed [W-1:0] da, logic signed [W-1:0] nb, logic signed [W-1:0] db);
		longint            an, ad, bn, bd, n, d;
		longint unsigned   x, y, r;
		fraction_t         res;
		an = longint'(na);
		ad = longint'(da);
		bn = longint'(nb);
		bd = longint'(db);
		case (op)
			OP_ADD: begin
				n = an * bd + bn * ad;
				d = ad * bd;
			end
			OP_SUB: begin
				n = an * bd - bn * ad;
				d = ad * bd;
			end
			OP_MUL: begin
				n = an * bn;
				d = ad * bd;
			end
			default: begin
				n = an * bd;
				d = ad * bn;
			end
		endcase
		res.err = 1'b0;
		if (d == 0) begin
			res.num = '0;
			res.den = '0;
			res.err = 1'b1;
		end else if (n == 0) begin
			res.num = '0;
			res.den = DEN_OUT_W'(1);
		end else begin
			x = (n < 0) ? -n : n;
			y = (d < 0) ? -d : d;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			// parts keep their own signs; only magnitudes are reduced
			res.num = NUM_OUT_W'(n / longint'(x));
			res.den = DEN_OUT_W'(d / longint'(x));
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reduced_q.delete();
			in_flight  <= 0;
			mismatches <= 0;
		end else begin
			bad = 0;
			if (rsp_valid && !rsp_stall) begin
				if (reduced_q.size() == 0) begin
					$display("%0t: result word with none expected: %0d/%0d status %0b",
						$time, res_num, res_den, status);
					bad++;
				end else begin
					want = reduced_q.pop_front();
					if (res_num !== want.num) begin
						$display("%0t: res_num expected %0d actual %0d", $time, want.num, res_num);
						bad++;
					end
					if (res_den !== want.den) begin
						$display("%0t: res_den expected %0d actual %0d", $time, want.den, res_den);
						bad++;
					end
					if (status !== want.err) begin
						$display("%0t: status expected %0b actual %0b", $time, want.err, status);
						bad++;
					end
				end
			end
			if (req_valid && !req_stall)
				reduced_q.push_back(reduce_fraction(op_t'(opcode), num_a, den_a, num_b, den_b));
			mismatches <= mismatches + bad;
			in_flight  <= reduced_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the fraction_arith_reduce testbench: clock, reset, operand and result
// traffic, watchdog and verdict. Depends on far_pkg, the block and fraction_check.
module tb;
	import far_pkg::*;

	localparam int W          = OPERAND_WIDTH_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_WORDS = 900;
	localparam logic signed [W-1:0] OPND_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] OPND_MAX = {1'b0, {(W-1){1'b1}}};

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    rsp_stall = 1'b1;
	op_t                     opcode    = OP_ADD;
	logic signed [W-1:0]     num_a     = '0;
	logic signed [W-1:0]     den_a     = '0;
	logic signed [W-1:0]     num_b     = '0;
	logic signed [W-1:0]     den_b     = '0;
	logic                    req_stall;
	logic                    rsp_valid;
	logic signed [NUM_OUT_W-1:0] res_num;
	logic signed [DEN_OUT_W-1:0] res_den;
	logic                    status;
	int                      mismatches;
	int                      in_flight;
	int                      idle_cycles = 0;
	int                      words_taken = 0;
	logic                    send_quiet  = 1'b0;
	logic                    take_quiet  = 1'b0;

	fraction_arith_reduce #(.OPERAND_WIDTH(W)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

	fraction_check #(.W(W)) u_check (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.res_num(res_num), .res_den(res_den), .status(status),
		.mismatches(mismatches), .in_flight(in_flight)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Valid stays high across back-to-back words; it is only lowered when a gap follows.
	task automatic send_word(op_t op, logic signed [W-1:0] na, logic signed [W-1:0] da,
		logic signed [W-1:0] nb, logic signed [W-1:0] db);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode    <= op;
		num_a     <= na;
		den_a     <= da;
		num_b     <= nb;
		den_b     <= db;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic logic signed [W-1:0] rand_operand();
		logic signed [W-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = W'($urandom);
			2: v = W'(int'($urandom_range(0, 40)) - 20);
			3: begin
				case ($urandom_range(0, 5))
					0: v = OPND_MIN;
					1: v = OPND_MIN + W'(1);
					2: v = OPND_MAX;
					3: v = -1;
					4: v = 0;
					default: v = 1;
				endcase
			end
			4: begin
				// small factor times a power of two: large common divisors
				v = W'($urandom_range(1, 15) << $urandom_range(0, W - 5));
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = W'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	// result side: random stall per word, plus one long hold-off to back up the block
	initial begin : result_side
		int n;
		@(posedge clk iff arst_n);
		forever begin
			if (words_taken % 40 == 0) take_quiet = ($urandom_range(0, 3) == 0);
			if (words_taken == 200) begin
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			n = take_quiet ? 0 : $urandom_range(0, 17);
			if (n == 0) begin
				rsp_stall <= 1'b0;
				do @(posedge clk); while (!rsp_valid);
			end else begin
				rsp_stall <= 1'b1;
				do @(posedge clk); while (!rsp_valid);
				repeat (n - 1) @(posedge clk);
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
			words_taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : operand_side
		op_t op;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_ADD, 1, 2, 1, 3);
		send_word(OP_SUB, 1, 2, 1, 2);     // cancels to zero numerator
		send_word(OP_SUB, 1, 3, 1, 2);
		send_word(OP_MUL, 1, 0, 1, 1);     // zero denominator
		send_word(OP_DIV, 1, 2, 0, 5);     // divide by a zero fraction
		send_word(OP_ADD, 0, 0, 0, 0);     // zero over zero: error wins
		send_word(OP_MUL, 0, 5, 3, 7);
		send_word(OP_DIV, 3, 4, 3, 4);
		send_word(OP_MUL, 1, -3, 1, 1);    // negative denominator kept
		send_word(OP_DIV, -6, 4, -9, -2);
		for (int k = 0; k < 4; k++) begin
			op = op_t'(k);
			send_word(op, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
			send_word(op, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
			send_word(op, OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN);
			send_word(op, OPND_MAX, -1, OPND_MIN, 1);
		end

		for (int i = 0; i < RAND_WORDS; i++) begin
			if (i % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
			if (i == RAND_WORDS / 2) begin
				// drain the block completely before going on
				req_valid <= 1'b0;
				@(posedge clk);
				while (in_flight != 0) @(posedge clk);
			end
			send_word(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
		end
		req_valid <= 1'b0;

		repeat (2) @(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== fraction_arith_reduce.f =====
sv/far_pkg.sv
sv/far_reduce.sv
sv/fraction_arith_reduce.sv
tb/fraction_check.sv
tb/tb.sv
